// ===== rtl/sampled_curve_integrator_defines.svh =====
// Assertion macros shared by the sampled curve integrator checkers.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef SAMPLED_CURVE_INTEGRATOR_DEFINES_SVH
`define SAMPLED_CURVE_INTEGRATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCI_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCI_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sci_pkg.sv =====
// Package for the sampled curve integrator: payload types, register codes,
// internal job and term types, and default sizes. Depends on nothing.
package sci_pkg;

    // Default queue depths.
    localparam int JOB_DEPTH_DEF = 4;
    localparam int RES_DEPTH_DEF = 4;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_LIMIT_ENABLE = 2'd0;
    localparam t_cfg_index CFG_LOWER_LIMIT  = 2'd1;
    localparam t_cfg_index CFG_UPPER_LIMIT  = 2'd2;

    // Reset values of the limit registers.
    localparam logic signed [31:0] LOWER_LIMIT_RESET = 32'sh0000_0000;
    localparam logic signed [31:0] UPPER_LIMIT_RESET = 32'sh7FFF_FFFF;

    // Saturation bounds of the Q32.32 accumulator.
    localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

    // One input sample point.
    typedef struct packed {
        logic signed [31:0] x_value;
        logic signed [31:0] y_value;
        logic               last_point;
    } t_in_item;

    // One integration result.
    typedef struct packed {
        logic signed [63:0] integral;
        logic               overflow;
    } t_out_item;

    // Configuration as seen by the arithmetic back end.
    typedef struct packed {
        logic               limit_enable;
        logic signed [31:0] lower_limit;
        logic signed [31:0] upper_limit;
    } t_cfg;

    // How many points of the current curve the front end has seen.
    typedef enum logic [1:0] {
        SEEN_NONE,
        SEEN_ONE,
        SEEN_TWO
    } t_seen;

    // Work for the back end caused by one accepted point: the term of the
    // pending point (a) and, at the end of a curve, the term of the point
    // itself (b). Both use the new point's x as their next x.
    typedef struct packed {
        logic               a_valid;
        logic               b_valid;
        logic signed [31:0] a_xprev;
        logic signed [31:0] a_y;
        logic signed [31:0] b_xprev;
        logic signed [31:0] b_y;
        logic signed [31:0] x_next;
    } t_job;

    // One term issued into the arithmetic pipeline.
    typedef struct packed {
        logic               last;
        logic signed [31:0] xprev;
        logic signed [31:0] xnext;
        logic signed [31:0] y;
    } t_term;

endpackage

// ===== rtl/sampled_curve_integrator.sv =====
// Sampled curve integrator, top level. A point is accepted every cycle while
// the job queue is not full; the point that closes a curve can carry two terms
// through the single accumulator adder in the back end, and its own term waits
// for a free result slot.
// Reset is synchronous and active low; it empties both queues, restarts the
// curve and returns the limit registers to their reset values.
module sampled_curve_integrator #(
    parameter int JOB_DEPTH = sci_pkg::JOB_DEPTH_DEF,
    parameter int RES_DEPTH = sci_pkg::RES_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  sci_pkg::t_in_item   i_in_item,
    output logic                empty,
    input  logic                pop,
    output sci_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  sci_pkg::t_cfg_index i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    logic               r_limit_enable;
    logic signed [31:0] r_lower_limit;
    logic signed [31:0] r_upper_limit;
    sci_pkg::t_cfg      cfg;

    logic               in_accept;
    sci_pkg::t_job      front_job;
    logic               front_job_valid;
    sci_pkg::t_job      head_job;
    logic               job_empty;
    logic               job_pop;
    logic               res_push;
    sci_pkg::t_out_item res_item;
    logic               res_taken;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;
    assign res_taken   = pop && !empty;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_enable <= 1'b0;
            r_lower_limit  <= sci_pkg::LOWER_LIMIT_RESET;
            r_upper_limit  <= sci_pkg::UPPER_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sci_pkg::CFG_LIMIT_ENABLE: r_limit_enable <= i_cfg_data[0];
                sci_pkg::CFG_LOWER_LIMIT:  r_lower_limit  <= i_cfg_data;
                sci_pkg::CFG_UPPER_LIMIT:  r_upper_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = '{limit_enable: r_limit_enable, lower_limit: r_lower_limit,
                   upper_limit: r_upper_limit};

    // Front end classifies points into term jobs.
    sci_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_accept    (in_accept),
        .o_job       (front_job),
        .o_job_valid (front_job_valid)
    );

    // Job queue between the front and back ends.
    sci_fifo #(
        .WIDTH ($bits(sci_pkg::t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept && front_job_valid),
        .i_data  (front_job),
        .o_full  (full),
        .o_empty (job_empty),
        .i_pop   (job_pop),
        .o_data  (head_job)
    );

    // Back end forms and accumulates terms.
    sci_back #(
        .RES_DEPTH (RES_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job       (head_job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .o_res_push  (res_push),
        .o_res_item  (res_item),
        .i_res_taken (res_taken)
    );

    // Result queue toward the consumer.
    sci_fifo #(
        .WIDTH ($bits(sci_pkg::t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .o_full  (),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (o_out_item)
    );

endmodule

// ===== rtl/sci_fifo.sv =====
// Small synchronous FIFO on a register file, used for the job queue and the
// result queue. Depends on nothing.
module sci_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointer and count updates.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage write; entries need no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/sci_front.sv =====
// Front end of the sampled curve integrator: tracks the last two points of
// the curve and turns accepted points into term jobs. Uses sci_pkg.
module sci_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sci_pkg::t_in_item i_item,
    input  logic              i_accept,
    output sci_pkg::t_job     o_job,
    output logic              o_job_valid
);

    sci_pkg::t_seen     r_seen, n_seen;
    logic signed [31:0] r_x_two_back;
    logic signed [31:0] r_x_one_back;
    logic signed [31:0] r_y_one_back;
    logic signed [31:0] own_prev;

    // The point's own previous x is itself at the start of a curve.
    assign own_prev = (r_seen == sci_pkg::SEEN_NONE) ? i_item.x_value : r_x_one_back;

    // Build the job: the pending point's term, and the own term at the end.
    always_comb begin
        o_job.a_valid = (r_seen != sci_pkg::SEEN_NONE);
        o_job.b_valid = i_item.last_point;
        o_job.a_xprev = (r_seen == sci_pkg::SEEN_ONE) ? r_x_one_back : r_x_two_back;
        o_job.a_y     = r_y_one_back;
        o_job.b_xprev = own_prev;
        o_job.b_y     = i_item.y_value;
        o_job.x_next  = i_item.x_value;
        o_job_valid   = o_job.a_valid || o_job.b_valid;
    end

    // Point counter advances up to two and restarts after the last point.
    always_comb begin
        n_seen = r_seen;
        if (i_accept) begin
            if (i_item.last_point) begin
                n_seen = sci_pkg::SEEN_NONE;
            end else begin
                case (r_seen)
                    sci_pkg::SEEN_NONE: n_seen = sci_pkg::SEEN_ONE;
                    sci_pkg::SEEN_ONE:  n_seen = sci_pkg::SEEN_TWO;
                    sci_pkg::SEEN_TWO:  n_seen = sci_pkg::SEEN_TWO;
                    default:            n_seen = sci_pkg::SEEN_NONE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= sci_pkg::SEEN_NONE;
        end else begin
            r_seen <= n_seen;
        end
    end

    // Point history; only read once the counter says it is filled.
    always_ff @(posedge i_clk) begin
        if (i_accept && !i_item.last_point) begin
            r_x_two_back <= own_prev;
            r_x_one_back <= i_item.x_value;
            r_y_one_back <= i_item.y_value;
        end
    end

endmodule

// ===== rtl/sci_back.sv =====
// Back end of the sampled curve integrator: issues terms from the job queue,
// forms y * |dx| / 2 in a pipeline and accumulates with saturation.
// Uses sci_pkg.
module sci_back #(
    parameter int RES_DEPTH = sci_pkg::RES_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sci_pkg::t_cfg      i_cfg,
    input  sci_pkg::t_job      i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output logic               o_res_push,
    output sci_pkg::t_out_item o_res_item,
    input  logic               i_res_taken
);

    localparam int CRD_W = $clog2(RES_DEPTH + 1);

    typedef struct packed {
        logic               last;
        logic               use_term;
        logic               stop;
        logic signed [31:0] y;
        logic        [32:0] span;
    } t_dist_stage;

    typedef struct packed {
        logic               last;
        logic               use_term;
        logic               stop;
        logic signed [63:0] product;
    } t_prod_stage;

    logic               r_phase, n_phase;
    logic [CRD_W-1:0]   r_res_used, n_res_used;
    logic               issue;
    logic               issue_last;
    sci_pkg::t_term     issue_term;

    logic               r_s1_valid;
    sci_pkg::t_term     r_s1;
    logic               r_s2_valid;
    t_dist_stage        r_s2;
    logic               r_s3_valid;
    t_prod_stage        r_s3;

    logic signed [32:0] diff;
    t_dist_stage        s1_out;
    logic signed [65:0] prod_full;
    t_prod_stage        s2_out;

    logic signed [63:0] r_sum, n_sum;
    logic               r_sat, n_sat;
    logic               r_stopped, n_stopped;
    logic signed [63:0] half_term;
    logic signed [64:0] sum_wide;

    // Issue: the pending term first, then the own term, which needs a free
    // result slot because it closes the curve.
    always_comb begin
        issue      = 1'b0;
        issue_last = 1'b0;
        o_job_pop  = 1'b0;
        n_phase    = r_phase;
        issue_term = '{last: 1'b0, xprev: i_job.a_xprev, xnext: i_job.x_next,
                       y: i_job.a_y};
        if (!i_job_empty) begin
            if (i_job.a_valid && !r_phase) begin
                issue     = 1'b1;
                o_job_pop = !i_job.b_valid;
                n_phase   = i_job.b_valid;
            end else if (r_res_used != CRD_W'(RES_DEPTH)) begin
                issue      = 1'b1;
                issue_last = 1'b1;
                o_job_pop  = 1'b1;
                n_phase    = 1'b0;
                issue_term = '{last: 1'b1, xprev: i_job.b_xprev, xnext: i_job.x_next,
                               y: i_job.b_y};
            end
        end
    end

    // Result slots reserved from issue of a closing term until its pop.
    always_comb begin
        n_res_used = r_res_used;
        if (issue_last && !i_res_taken) begin
            n_res_used = r_res_used + 1'b1;
        end else if (!issue_last && i_res_taken) begin
            n_res_used = r_res_used - 1'b1;
        end
    end

    // Stage one: distance and limit decisions.
    always_comb begin
        diff            = {r_s1.xnext[31], r_s1.xnext} - {r_s1.xprev[31], r_s1.xprev};
        s1_out.last     = r_s1.last;
        s1_out.y        = r_s1.y;
        s1_out.span     = diff[32] ? 33'(-diff) : 33'(diff);
        s1_out.use_term = !i_cfg.limit_enable || (r_s1.xprev > i_cfg.lower_limit);
        s1_out.stop     = i_cfg.limit_enable && (r_s1.xprev > i_cfg.upper_limit);
    end

    // Stage two: signed y times unsigned distance; the product fits 64 bits.
    always_comb begin
        prod_full       = $signed({{34{r_s2.y[31]}}, r_s2.y}) * $signed({33'd0, r_s2.span});
        s2_out.last     = r_s2.last;
        s2_out.use_term = r_s2.use_term;
        s2_out.stop     = r_s2.stop;
        s2_out.product  = prod_full[63:0];
    end

    // Stage three: halve with floor rounding and add with saturation, skipping unused terms and all terms after a stop.
    always_comb begin
        half_term = r_s3.product >>> 1;
        sum_wide  = {r_sum[63], r_sum} + {half_term[63], half_term};
        n_sum     = r_sum;
        n_sat     = r_sat;
        n_stopped = r_stopped;
        if (r_s3_valid && !r_stopped) begin
            if (r_s3.use_term) begin
                if (sum_wide[64:63] == 2'b01) begin
                    n_sum = sci_pkg::SUM_MAX;
                    n_sat = 1'b1;
                end else if (sum_wide[64:63] == 2'b10) begin
                    n_sum = sci_pkg::SUM_MIN;
                    n_sat = 1'b1;
                end else begin
                    n_sum = sum_wide[63:0];
                end
            end
            n_stopped = r_s3.stop;
        end
    end

    // The closing term hands the total to the result queue.
    assign o_res_push          = r_s3_valid && r_s3.last;
    assign o_res_item.integral = n_sum;
    assign o_res_item.overflow = n_sat;

    // Control and accumulator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= 1'b0;
            r_res_used <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_sum      <= '0;
            r_sat      <= 1'b0;
            r_stopped  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_res_used <= n_res_used;
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (o_res_push) begin
                r_sum     <= '0;
                r_sat     <= 1'b0;
                r_stopped <= 1'b0;
            end else begin
                r_sum     <= n_sum;
                r_sat     <= n_sat;
                r_stopped <= n_stopped;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        r_s1 <= issue_term;
        r_s2 <= s1_out;
        r_s3 <= s2_out;
    end

endmodule

// ===== rtl/sci_checker.sv =====
// Port-level checks of the sampled curve integrator, bound to the top level.
// Uses sci_pkg and the macros of sampled_curve_integrator_defines.svh.
`include "sampled_curve_integrator_defines.svh"

module sci_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input sci_pkg::t_out_item i_out_item
);

    // Reset leaves the result queue empty and the job queue not full.
    `SCI_ASSERT_NEXT(a_reset_clears, i_clk, 1'b0, !i_rst_n, empty && !full, "queues not empty after reset")

    // A waiting result holds until it is taken.
    `SCI_ASSERT_NEXT(a_result_holds, i_clk, !i_rst_n, !empty && !pop, !empty && $stable(i_out_item), "result changed while waiting")

    // The result queue drains only by a pop transaction.
    `SCI_ASSERT_SAME(a_empty_by_pop, i_clk, !i_rst_n, $rose(empty) && $past(i_rst_n), $past(pop), "result lost without a pop")

    // The input side fills only by a push transaction.
    `SCI_ASSERT_SAME(a_full_by_push, i_clk, !i_rst_n, $rose(full) && $past(i_rst_n), $past(push), "input side full without a push")

endmodule

bind sampled_curve_integrator sci_checker u_sci_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .push       (push),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .i_out_item (o_out_item)
);
